@@ sv/ole_pkg.sv @@
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int Capacity  = 64;
    localparam int IdxW      = $clog2(Capacity);
    localparam int CntW      = $clog2(Capacity + 1);
    localparam int ItemW     = 32;
    localparam int CmdW      = 3;
    localparam int PosW      = 10;
    localparam int StatW     = 2;
    localparam int FoundW    = 10;
    localparam int EcntW     = 11;

    localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CmdW-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CmdW-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CmdW-1:0] CMD_INSERT     = 3'd4;
    localparam logic [CmdW-1:0] CMD_REMOVE     = 3'd5;
    localparam logic [CmdW-1:0] CMD_FIND       = 3'd6;
    localparam logic [CmdW-1:0] CMD_CLEAR      = 3'd7;

    localparam logic [StatW-1:0] ST_DONE     = 2'd0;
    localparam logic [StatW-1:0] ST_RANGE    = 2'd1;
    localparam logic [StatW-1:0] ST_FULL     = 2'd2;
    localparam logic [StatW-1:0] ST_NOTFOUND = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic            exec;   // apply the decoded operation
        logic            out_take; // result taken
    } ole_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic            res_valid;
    } ole_stat_t;

endpackage

@@ sv/ole_datapath.sv @@
// ----------------------------------------------------------------------------
// ole_datapath
// Row of item cells that shift and compare in parallel, plus the result
// register.
// ----------------------------------------------------------------------------
module ole_datapath import ole_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  ole_cmd_t            ctl,
    output ole_stat_t           sts,
    input  logic [CmdW-1:0]     in_cmd,
    input  logic [PosW-1:0]     in_pos,
    input  logic [ItemW-1:0]    in_val,
    output logic [StatW-1:0]    res_status,
    output logic [ItemW-1:0]    res_item,
    output logic [FoundW-1:0]   res_found,
    output logic [EcntW-1:0]    res_count
);

    logic [ItemW-1:0] cell_reg [Capacity];
    logic [ItemW-1:0] cell_next [Capacity];
    logic [CntW-1:0]  used_reg, used_next;
    logic             rv_reg, rv_next;
    logic [StatW-1:0] st_reg, st_next;
    logic [ItemW-1:0] it_reg, it_next;
    logic [FoundW-1:0] fp_reg, fp_next;

    logic [CntW-1:0]  ipos;      // insert target
    logic [CntW-1:0]  rpos;      // remove target
    logic             do_ins, do_rem;
    logic [Capacity-1:0] hit;
    logic [IdxW-1:0]  first_hit;
    logic             any_hit;
    logic             full, empty;
    logic [IdxW-1:0]  rsel;

    assign full  = (used_reg == CntW'(Capacity));
    assign empty = (used_reg == '0);

    always_comb begin
        for (int i = 0; i < Capacity; i++) begin
            hit[i] = (CntW'(i) < used_reg) && (cell_reg[i] == in_val);
        end
        first_hit = '0;
        any_hit   = 1'b0;
        for (int i = Capacity - 1; i >= 0; i--) begin
            if (hit[i]) begin
                first_hit = IdxW'(i);
                any_hit   = 1'b1;
            end
        end
    end

    always_comb begin
        st_next   = st_reg;
        it_next   = it_reg;
        fp_next   = fp_reg;
        used_next = used_reg;
        rv_next   = rv_reg;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        ipos      = used_reg;
        rpos      = '0;
        if (ctl.out_take) begin
            rv_next = 1'b0;
        end
        if (ctl.exec) begin
            rv_next = 1'b1;
            st_next = ST_DONE;
            it_next = '0;
            fp_next = '0;
            unique case (in_cmd)
                CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                    if (full) begin
                        st_next = ST_FULL;
                    end else begin
                        do_ins = 1'b1;
                        if (in_cmd == CMD_PUSH_FRONT) begin
                            ipos = '0;
                        end else if (in_cmd == CMD_INSERT &&
                                     {1'b0, in_pos} < EcntW'(used_reg)) begin
                            ipos = CntW'(in_pos);
                        end
                    end
                end
                CMD_POP_BACK, CMD_POP_FRONT: begin
                    if (empty) begin
                        st_next = ST_RANGE;
                    end else begin
                        do_rem = 1'b1;
                        rpos = (in_cmd == CMD_POP_BACK) ? used_reg - 1'b1 : '0;
                    end
                end
                CMD_REMOVE: begin
                    if ({1'b0, in_pos} >= EcntW'(used_reg)) begin
                        st_next = ST_RANGE;
                    end else begin
                        do_rem = 1'b1;
                        rpos = CntW'(in_pos);
                    end
                end
                CMD_FIND: begin
                    if (any_hit) begin
                        fp_next = FoundW'(first_hit);
                    end else begin
                        st_next = ST_NOTFOUND;
                    end
                end
                CMD_CLEAR: begin
                    used_next = '0;
                end
                default: ;
            endcase
            if (do_ins) used_next = used_reg + 1'b1;
            if (do_rem) used_next = used_reg - 1'b1;
        end
    end

    assign rsel = rpos[IdxW-1:0];

    always_comb begin
        for (int i = 0; i < Capacity; i++) begin
            cell_next[i] = cell_reg[i];
            if (do_ins) begin
                if (CntW'(i) == ipos) cell_next[i] = in_val;
                else if (CntW'(i) > ipos && i > 0) cell_next[i] = cell_reg[(i + Capacity - 1) % Capacity];
            end else if (do_rem) begin
                if (CntW'(i) >= rpos && i < Capacity - 1) cell_next[i] = cell_reg[(i + 1) % Capacity];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < Capacity; i++) cell_reg[i] <= cell_next[i];
        if (do_rem) it_reg <= cell_reg[rsel];
        else        it_reg <= it_next;
        st_reg <= st_next;
        fp_reg <= fp_next;
        if (!aresetn) begin
            used_reg <= '0;
            rv_reg   <= 1'b0;
        end else begin
            used_reg <= used_next;
            rv_reg   <= rv_next;
        end
    end

    assign sts.res_valid = rv_reg;
    assign res_status = st_reg;
    assign res_item   = it_reg;
    assign res_found  = fp_reg;
    assign res_count  = EcntW'(used_reg);

endmodule

@@ sv/ole_ctrl.sv @@
// ----------------------------------------------------------------------------
// ole_ctrl
// Handshake controller: takes one command per cycle into the cell row while the
// output side takes results, and holds the result until the output side takes it.
// ----------------------------------------------------------------------------
module ole_ctrl import ole_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output ole_cmd_t  ctl,
    input  ole_stat_t sts
);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_IDLE_RST = 1'b1;

    logic state_reg, state_next;

    always_comb begin
        state_next = ST_RUN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE_RST;
        else          state_reg <= state_next;
    end

    // result register may refill in the same cycle it drains
    assign s_tready     = (state_reg == ST_RUN) && (!sts.res_valid || m_tready);
    assign m_tvalid     = sts.res_valid;
    assign ctl.exec     = s_tvalid && s_tready;
    assign ctl.out_take = sts.res_valid && m_tready;

endmodule

@@ sv/ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// ordered_list_engine_core
// Bounded ordered list: a row of item cells shifted in parallel.
// ----------------------------------------------------------------------------
// The result is registered and goes valid in the cycle after input accept.
// Throughput: 1 item per cycle while m_tready holds; the result register drains and refills at once.
// The cell row shifts and compares in parallel for each command.
// Reset: synchronous, active low; length clears, cells hold until written.
// Ready is low in the cycle after reset.
module ordered_list_engine_core import ole_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // command[2:0], position[12:3], item_value[44:13]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata   // status[1:0], item_out[33:2], found_position[43:34],
                                  // entry_count[54:44]
);

    ole_cmd_t  ctl;
    ole_stat_t sts;
    logic [StatW-1:0]  st;
    logic [ItemW-1:0]  it;
    logic [FoundW-1:0] fp;
    logic [EcntW-1:0]  ec;

    ole_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .ctl, .sts
    );

    ole_datapath u_dp (
        .aclk, .aresetn, .ctl, .sts,
        .in_cmd (s_tdata[2:0]),
        .in_pos (s_tdata[12:3]),
        .in_val (s_tdata[44:13]),
        .res_status (st),
        .res_item   (it),
        .res_found  (fp),
        .res_count  (ec)
    );

    assign m_tdata = {1'b0, ec, fp, it, st};

endmodule

@@ sv/ole_checker.sv @@
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks for the ordered list engine.
// ----------------------------------------------------------------------------
module ole_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after accept");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[54:44] <= 11'd64)
        else $error("length beyond capacity");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata[2:0] == 3'd7 |=>
        m_tdata[54:44] == 11'd0 && m_tdata[1:0] == 2'd0)
        else $error("clear did not empty list");

endmodule

bind ordered_list_engine_core ole_checker u_ole_checker (.*);

@@ test/tb_ordered_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_core
// Self-checking bench: list commands in, predicted status/item/position/length
// compared against every result item, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_core;
    import ole_pkg::*;

    typedef struct packed {
        logic [ItemW-1:0] value;
        logic [PosW-1:0]  pos;
        logic [CmdW-1:0]  cmd;
    } list_cmd_t;

    typedef struct packed {
        logic [EcntW-1:0]  count;
        logic [FoundW-1:0] found;
        logic [ItemW-1:0]  taken;
        logic [StatW-1:0]  status;
    } list_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;

    ordered_list_engine_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    list_cmd_t        cmd_queue[$];
    list_res_t        expected_results[$];
    logic [ItemW-1:0] shadow_list[$];
    int               errors = 0;
    bit               calm = 1'b0;     // no idling in the last part
    bit               drain_req = 1'b0; // sender pauses until all results in
    bit               hold_rx = 1'b0;   // long receiver hold-off
    int               tx_gap = 0;
    int               rx_gap = 0;

    // Predict the result of one command and update the shadow list.
    function automatic list_res_t list_predict(list_cmd_t c);
        list_res_t r;
        int        n;
        r = '0;
        n = shadow_list.size();
        case (c.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                if (n >= Capacity) r.status = ST_FULL;
                else if (c.cmd == CMD_PUSH_BACK) shadow_list.push_back(c.value);
                else if (c.cmd == CMD_PUSH_FRONT) shadow_list.push_front(c.value);
                else if (c.pos < n) shadow_list.insert(c.pos, c.value);
                else shadow_list.push_back(c.value);
            end
            CMD_POP_BACK: begin
                if (n == 0) r.status = ST_RANGE;
                else r.taken = shadow_list.pop_back();
            end
            CMD_POP_FRONT: begin
                if (n == 0) r.status = ST_RANGE;
                else r.taken = shadow_list.pop_front();
            end
            CMD_REMOVE: begin
                if (c.pos >= n) r.status = ST_RANGE;
                else begin
                    r.taken = shadow_list[c.pos];
                    shadow_list.delete(c.pos);
                end
            end
            CMD_FIND: begin
                r.status = ST_NOTFOUND;
                for (int i = 0; i < n; i++) begin
                    if (shadow_list[i] == c.value) begin
                        r.status = ST_DONE;
                        r.found = FoundW'(i);
                        break;
                    end
                end
            end
            default: shadow_list.delete();
        endcase
        r.count = EcntW'(shadow_list.size());
        return r;
    endfunction

    function automatic list_cmd_t mk(logic [CmdW-1:0] c, int p, int v);
        list_cmd_t x;
        x.cmd = c;
        x.pos = PosW'(p);
        x.value = ItemW'(v);
        return x;
    endfunction

    // Random commands biased by phase: fill-heavy, drain-heavy or mixed.
    function automatic list_cmd_t rand_cmd(int bias);
        list_cmd_t x;
        int        r;
        r = $urandom_range(99);
        x.value = ($urandom_range(3) == 0) ? $urandom : $urandom_range(15);
        x.pos = ($urandom_range(4) == 0) ? PosW'($urandom) : PosW'($urandom_range(70));
        if (r < bias) x.cmd = ($urandom_range(2) == 0) ? CMD_PUSH_BACK :
                              ($urandom_range(1) ? CMD_PUSH_FRONT : CMD_INSERT);
        else if (r < 90) x.cmd = CmdW'($urandom_range(6));
        else if (r < 98) x.cmd = CMD_FIND;
        else x.cmd = CMD_CLEAR;
        return x;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(list_predict(list_cmd_t'(s_tdata[44:0])));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (drain_req && (expected_results.size() != 0 ||
                             (s_tvalid && s_tready))) begin
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    if (!calm && $urandom_range(9) == 0) begin
                        tx_gap <= $urandom_range(19, 1) - 1;
                        s_tvalid <= 1'b0;
                    end else begin
                        s_tdata <= {3'b0, cmd_queue.pop_front()};
                        s_tvalid <= 1'b1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge aclk) begin
        list_res_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[54:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result item %h", $time, got);
                    errors <= errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        $display({"%0t: expected st=%0d item=%h pos=%0d cnt=%0d, ",
                                  "got st=%0d item=%h pos=%0d cnt=%0d"},
                                 $time, want.status, want.taken, want.found, want.count,
                                 got.status, got.taken, got.found, got.count);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_rx) m_tready <= 1'b0;
            else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(9) == 0) begin
                rx_gap <= $urandom_range(19, 1) - 1;
                m_tready <= 1'b0;
            end else m_tready <= 1'b1;
        end
    end

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty-list cases, ends, positions, full list
        cmd_queue.push_back(mk(CMD_POP_BACK, 0, 0));
        cmd_queue.push_back(mk(CMD_POP_FRONT, 0, 0));
        cmd_queue.push_back(mk(CMD_REMOVE, 0, 0));
        cmd_queue.push_back(mk(CMD_FIND, 0, 0));
        cmd_queue.push_back(mk(CMD_PUSH_BACK, 10'h3FF, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk(CMD_PUSH_FRONT, 0, 32'h0));
        cmd_queue.push_back(mk(CMD_INSERT, 0, 32'h1));
        cmd_queue.push_back(mk(CMD_INSERT, 10'h3FF, 32'h2));
        cmd_queue.push_back(mk(CMD_INSERT, 2, 32'h5555_AAAA));
        cmd_queue.push_back(mk(CMD_FIND, 10'h3FF, 32'hFFFF_FFFF));
        cmd_queue.push_back(mk(CMD_FIND, 0, 32'h1234_5678));
        cmd_queue.push_back(mk(CMD_REMOVE, 5, 0));
        cmd_queue.push_back(mk(CMD_REMOVE, 10'h3FF, 0));
        cmd_queue.push_back(mk(CMD_REMOVE, 1, 0));
        cmd_queue.push_back(mk(CMD_POP_BACK, 0, 0));
        cmd_queue.push_back(mk(CMD_POP_FRONT, 0, 0));
        cmd_queue.push_back(mk(CMD_CLEAR, 0, 0));
        for (int i = 0; i < Capacity + 2; i++)
            cmd_queue.push_back(mk(CMD_PUSH_BACK, 0, i));
        cmd_queue.push_back(mk(CMD_PUSH_FRONT, 0, 1));
        cmd_queue.push_back(mk(CMD_INSERT, 3, 1));
        cmd_queue.push_back(mk(CMD_FIND, 0, Capacity - 1));
        cmd_queue.push_back(mk(CMD_REMOVE, Capacity - 1, 0));
        wait_drained();

        // receiver holds off long while sender keeps offering
        hold_rx = 1'b1;
        for (int i = 0; i < 40; i++) cmd_queue.push_back(rand_cmd(50));
        repeat (200) @(posedge aclk);
        hold_rx = 1'b0;
        wait_drained();

        // sender pauses until everything is back
        drain_req = 1'b1;
        for (int i = 0; i < 20; i++) cmd_queue.push_back(rand_cmd(50));
        wait_drained();
        drain_req = 1'b0;

        for (int ph = 0; ph < 10; ph++) begin
            for (int i = 0; i < 110; i++)
                cmd_queue.push_back(rand_cmd((ph % 2) ? 20 : 70));
            if (ph == 9) calm = 1'b1;
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
